@@ hdl/adpalu_pkg.sv @@
// Shared types and constants for the data-processing ALU pipeline.
`default_nettype none

package adpalu_pkg;

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] rn_value;
		logic [31:0] rm_value;
		logic [31:0] rs_value;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] alu_result;
		logic        reg_write;
		logic [3:0]  dest_reg;
		logic        flags_write;
		logic        flag_n;
		logic        flag_z;
		logic        flag_c;
		logic        invalid_op;
	} alu_rsp_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic       set_flags;
		logic [3:0] rd;
		logic       writes;
		logic       logical;
		logic       valid_op;
	} alu_ctl_t;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  amount;
		logic [1:0]  kind;
	} shift_req_t;

endpackage

`default_nettype wire

@@ hdl/adpalu_decode.sv @@
// First pipeline stage: instruction decode and operand 2 shift request.
`default_nettype none

module adpalu_decode (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_vld,
	input  wire adpalu_pkg::alu_req_t req,
	output logic                    vld_s1,
	output adpalu_pkg::alu_ctl_t    ctl_s1,
	output adpalu_pkg::shift_req_t  shreq_s1,
	output logic [31:0]             rn_s1
);
	import adpalu_pkg::*;

	alu_ctl_t   ctl_d;
	shift_req_t shreq_d;
	logic [31:0] ins;

	assign ins = req.instr_word;

	always_comb begin
		ctl_d.opcode    = ins[24:21];
		ctl_d.set_flags = ins[20];
		ctl_d.rd        = ins[15:12];
		ctl_d.writes    = 1'b0;
		ctl_d.logical   = 1'b0;
		ctl_d.valid_op  = 1'b1;
		unique case (ins[24:21])
			OP_AND, OP_EOR, OP_ORR, OP_MOV: begin
				ctl_d.writes  = 1'b1;
				ctl_d.logical = 1'b1;
			end
			OP_SUB, OP_RSB, OP_ADD: ctl_d.writes = 1'b1;
			OP_TST, OP_TEQ: ctl_d.logical = 1'b1;
			OP_CMP: ctl_d.writes = 1'b0;
			default: ctl_d.valid_op = 1'b0;
		endcase

		if (ins[25]) begin
			shreq_d.value  = {24'd0, ins[7:0]};
			shreq_d.amount = {3'd0, ins[11:8], 1'b0};
			shreq_d.kind   = SH_ROR;
		end else begin
			shreq_d.value  = req.rm_value;
			shreq_d.amount = ins[4] ? req.rs_value[7:0] : {3'd0, ins[11:7]};
			shreq_d.kind   = ins[6:5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1   <= ctl_d;
		shreq_s1 <= shreq_d;
		rn_s1    <= req.rn_value;
	end

endmodule

`default_nettype wire

@@ hdl/adpalu_shift.sv @@
// Second pipeline stage: barrel shifter that forms operand 2 and the shifter carry.
`default_nettype none

module adpalu_shift (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     vld_s1,
	input  wire adpalu_pkg::alu_ctl_t ctl_s1,
	input  wire adpalu_pkg::shift_req_t shreq_s1,
	input  wire [31:0]              rn_s1,
	output logic                    vld_s2,
	output adpalu_pkg::alu_ctl_t    ctl_s2,
	output logic [31:0]             op2_s2,
	output logic                    shc_s2,
	output logic [31:0]             rn_s2
);
	import adpalu_pkg::*;

	logic [31:0] v;
	logic [7:0]  amt;
	logic [5:0]  amt_lg;
	logic [5:0]  amt_ar;
	logic [32:0] lsl_w;
	logic [32:0] lsr_w;
	logic [32:0] asr_w;
	logic [31:0] ror_w;
	logic [31:0] op2_d;
	logic        shc_d;

	assign v   = shreq_s1.value;
	assign amt = shreq_s1.amount;

	always_comb begin
		amt_lg = (amt > 8'd32) ? 6'd33 : amt[5:0];
		amt_ar = (amt > 8'd32) ? 6'd32 : amt[5:0];
		lsl_w  = {1'b0, v} << amt_lg;
		lsr_w  = {v, 1'b0} >> amt_lg;
		asr_w  = 33'($signed({v, 1'b0}) >>> amt_ar);
		ror_w  = 32'({v, v} >> amt[4:0]);
		if (amt == 8'd0) begin
			op2_d = v;
			shc_d = 1'b0;
		end else begin
			unique case (shreq_s1.kind)
				SH_LSL: begin
					op2_d = lsl_w[31:0];
					shc_d = lsl_w[32];
				end
				SH_LSR: begin
					op2_d = lsr_w[32:1];
					shc_d = lsr_w[0];
				end
				SH_ASR: begin
					op2_d = asr_w[32:1];
					shc_d = asr_w[0];
				end
				default: begin
					op2_d = ror_w;
					shc_d = ror_w[31];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		op2_s2 <= op2_d;
		shc_s2 <= shc_d;
		rn_s2  <= rn_s1;
	end

endmodule

`default_nettype wire

@@ hdl/adpalu_exec.sv @@
// Third pipeline stage: adder and logic unit, flag generation and result register.
`default_nettype none

module adpalu_exec (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     vld_s2,
	input  wire adpalu_pkg::alu_ctl_t ctl_s2,
	input  wire [31:0]              op2_s2,
	input  wire                     shc_s2,
	input  wire [31:0]              rn_s2,
	output logic                    vld_s3,
	output adpalu_pkg::alu_rsp_t    rsp_s3
);
	import adpalu_pkg::*;

	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_ci;
	logic [32:0] sum;
	logic [31:0] res;
	logic        carry;
	alu_rsp_t    rsp_d;

	always_comb begin
		add_a  = rn_s2;
		add_b  = op2_s2;
		add_ci = 1'b0;
		if (ctl_s2.opcode == OP_SUB || ctl_s2.opcode == OP_CMP) begin
			add_b  = ~op2_s2;
			add_ci = 1'b1;
		end else if (ctl_s2.opcode == OP_RSB) begin
			add_a  = op2_s2;
			add_b  = ~rn_s2;
			add_ci = 1'b1;
		end
		sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};

		unique case (ctl_s2.opcode)
			OP_AND, OP_TST: res = rn_s2 & op2_s2;
			OP_EOR, OP_TEQ: res = rn_s2 ^ op2_s2;
			OP_SUB, OP_RSB, OP_ADD, OP_CMP: res = sum[31:0];
			OP_ORR: res = rn_s2 | op2_s2;
			OP_MOV: res = op2_s2;
			default: res = 32'd0;
		endcase
		carry = ctl_s2.logical ? shc_s2 : sum[32];

		if (ctl_s2.valid_op) begin
			rsp_d.alu_result  = res;
			rsp_d.reg_write   = ctl_s2.writes;
			rsp_d.dest_reg    = ctl_s2.writes ? ctl_s2.rd : 4'd0;
			rsp_d.flags_write = ctl_s2.set_flags;
			rsp_d.flag_n      = ctl_s2.set_flags & res[31];
			rsp_d.flag_z      = ctl_s2.set_flags & (res == 32'd0);
			rsp_d.flag_c      = ctl_s2.set_flags & carry;
			rsp_d.invalid_op  = 1'b0;
		end else begin
			rsp_d            = '0;
			rsp_d.invalid_op = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s3 <= rsp_d;
	end

endmodule

`default_nettype wire

@@ hdl/arm_data_processing_alu.sv @@
// Top level of the three-stage ARM data-processing ALU pipeline.
//
//   Channel   Handshake            Payload  Direction
//   command   start / busy         req      in
//   response  done (one cycle)     rsp      out
//
// A transaction is accepted at every edge where start is high; busy is always low.
// Each transaction passes through decode, barrel shift, then add/logic with flags.
// One transaction may enter every cycle; each stage holds at most one in flight.
// Reset clears the stage valid bits only; the data registers are not reset.
// The receiver cannot stall, so the pipeline never holds or drops a transaction.
`default_nettype none

module arm_data_processing_alu (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire adpalu_pkg::alu_req_t req,
	output logic                  done,
	output adpalu_pkg::alu_rsp_t  rsp
);
	import adpalu_pkg::*;

	logic        vld_s1;
	alu_ctl_t    ctl_s1;
	shift_req_t  shreq_s1;
	logic [31:0] rn_s1;
	logic        vld_s2;
	alu_ctl_t    ctl_s2;
	logic [31:0] op2_s2;
	logic        shc_s2;
	logic [31:0] rn_s2;

	assign busy = 1'b0;

	adpalu_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start & ~busy),
		.req      (req),
		.vld_s1   (vld_s1),
		.ctl_s1   (ctl_s1),
		.shreq_s1 (shreq_s1),
		.rn_s1    (rn_s1)
	);

	adpalu_shift u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.ctl_s1   (ctl_s1),
		.shreq_s1 (shreq_s1),
		.rn_s1    (rn_s1),
		.vld_s2   (vld_s2),
		.ctl_s2   (ctl_s2),
		.op2_s2   (op2_s2),
		.shc_s2   (shc_s2),
		.rn_s2    (rn_s2)
	);

	adpalu_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.ctl_s2 (ctl_s2),
		.op2_s2 (op2_s2),
		.shc_s2 (shc_s2),
		.rn_s2  (rn_s2),
		.vld_s3 (done),
		.rsp_s3 (rsp)
	);

	// Every accepted transaction completes after passing through decode, shift and execute.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##2 done)
		else $error("accepted transaction did not complete after three cycles");

	// An invalid opcode writes nothing.
	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.invalid_op |-> rsp.alu_result == 32'd0 && !rsp.reg_write &&
			rsp.dest_reg == 4'd0 && !rsp.flags_write)
		else $error("invalid opcode produced a write");

	// Flags stay clear unless they are written.
	a_flags_gated: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.flags_write |-> !rsp.flag_n && !rsp.flag_z && !rsp.flag_c)
		else $error("flags set without a flag write");

	// Z and N follow the result when flags are written.
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.flags_write |-> rsp.flag_z == (rsp.alu_result == 32'd0) &&
			rsp.flag_n == rsp.alu_result[31])
		else $error("N or Z flag disagrees with the result");

endmodule

`default_nettype wire
